// ===== rtl/core/bmms_pkg.sv =====
// ----------------------------------------------------------------------------
// bmms_pkg
// Shared types and constants for the batch min/max/median statistics block.
// ----------------------------------------------------------------------------
package bmms_pkg;

    localparam int COUNT_DEF       = 64;
    localparam int SAMPLE_BITS_DEF = 16;

    // never_below test: MIN_SCALE * min >= max
    localparam int MIN_SCALE       = 20;
    localparam int MIN_SCALE_BITS  = 5;

    // handoff from one sort cell to its right-hand neighbor
    typedef struct packed {
        logic gt;     // neighbor's stored word is greater than the new word (or empty)
        logic valid;  // neighbor holds a sample of the current batch
    } t_link;

endpackage

// ===== rtl/core/bmms_cell.sv =====
// ----------------------------------------------------------------------------
// bmms_cell
// One slot of the insertion sort chain. Holds one sample; on each accepted
// word it keeps its value, takes the new word, or takes its left neighbor's.
// ----------------------------------------------------------------------------
module bmms_cell #(
    parameter int SAMPLE_BITS = bmms_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_clear,
    input  logic [SAMPLE_BITS-1:0] i_level,
    input  logic [SAMPLE_BITS-1:0] i_left_level,
    input  bmms_pkg::t_link        i_left,
    output logic [SAMPLE_BITS-1:0] o_level,
    output logic [SAMPLE_BITS-1:0] o_next_level,
    output bmms_pkg::t_link        o_link
);
    import bmms_pkg::*;

    logic [SAMPLE_BITS-1:0] r_level;
    logic [SAMPLE_BITS-1:0] n_level;
    logic                   r_valid;
    logic                   w_gt;

    // strict compare: equal words stay ahead of the new one
    assign w_gt = !r_valid || (r_level > i_level);

    always_comb begin
        if (!w_gt) begin
            n_level = r_level;
        end else if (i_left.gt) begin
            n_level = i_left_level;
        end else begin
            n_level = i_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_clear ? 1'b0 : i_left.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_level <= n_level;
        end
    end

    assign o_level      = r_level;
    assign o_next_level = n_level;
    assign o_link.gt    = w_gt;
    assign o_link.valid = r_valid;

endmodule

// ===== rtl/core/batch_min_max_median_stats_top.sv =====
// ----------------------------------------------------------------------------
// batch_min_max_median_stats_top
// Batch statistics: min, max, 5% floor flag, first-minus-last and twice the
// median over COUNT samples, sorted on the fly by a chain of insertion cells.
// ----------------------------------------------------------------------------
// channel  | direction | handshake          | payload
// sample   | in        | start & !busy      | i_level
// result   | out       | o_valid, 1 cycle   | o_min_level, o_max_level,
//          |           |                    | o_never_below, o_consumption,
//          |           |                    | o_median_twice
//
// One sample per cycle; busy stays low. The sort chain inserts each word in
// the cycle it is accepted, every cell deciding in parallel against its left
// neighbor. The result strobes in the cycle after the COUNT-th sample is accepted.
// Synchronous reset empties the chain and restarts the batch; the result
// port cannot be stalled.
// ----------------------------------------------------------------------------
module batch_min_max_median_stats_top #(
    parameter int COUNT       = bmms_pkg::COUNT_DEF,
    parameter int SAMPLE_BITS = bmms_pkg::SAMPLE_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [SAMPLE_BITS-1:0]  i_level,
    output logic                    o_valid,
    output logic [SAMPLE_BITS-1:0]  o_min_level,
    output logic [SAMPLE_BITS-1:0]  o_max_level,
    output logic                    o_never_below,
    output logic signed [SAMPLE_BITS:0] o_consumption,
    output logic [SAMPLE_BITS:0]    o_median_twice
);
    import bmms_pkg::*;

    localparam int CNT_BITS = $clog2(COUNT + 1);
    localparam int MID_HI   = COUNT / 2;
    localparam int MID_LO   = (COUNT % 2 == 0) ? (COUNT / 2 - 1) : (COUNT / 2);
    localparam int PROD_BITS = SAMPLE_BITS + MIN_SCALE_BITS;

    logic                   w_accept;
    logic                   w_last;
    logic [SAMPLE_BITS-1:0] w_level  [COUNT];
    logic [SAMPLE_BITS-1:0] w_next   [COUNT];
    logic [SAMPLE_BITS-1:0] w_left_level [COUNT];
    t_link                  w_link   [COUNT+1];

    logic [CNT_BITS-1:0]    r_count;
    logic [SAMPLE_BITS-1:0] r_min;
    logic [SAMPLE_BITS-1:0] r_max;
    logic [SAMPLE_BITS-1:0] r_first;
    logic [SAMPLE_BITS-1:0] n_min;
    logic [SAMPLE_BITS-1:0] n_max;
    logic [SAMPLE_BITS-1:0] w_first;
    logic [PROD_BITS-1:0]   w_min_scaled;

    logic                   r_valid;
    logic [SAMPLE_BITS-1:0] r_min_level;
    logic [SAMPLE_BITS-1:0] r_max_level;
    logic                   r_never_below;
    logic [SAMPLE_BITS:0]   r_consumption;
    logic [SAMPLE_BITS:0]   r_median_twice;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_last   = (r_count == CNT_BITS'(COUNT - 1));

    // head of the chain: always valid, never shifts in
    assign w_link[0].gt    = 1'b0;
    assign w_link[0].valid = 1'b1;

    genvar g;
    generate
        for (g = 0; g < COUNT; g++) begin : g_cell
            if (g == 0) begin : g_head
                assign w_left_level[g] = i_level;
            end else begin : g_body
                assign w_left_level[g] = w_level[g-1];
            end
            bmms_cell #(
                .SAMPLE_BITS (SAMPLE_BITS)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_en         (w_accept),
                .i_clear      (w_last),
                .i_level      (i_level),
                .i_left_level (w_left_level[g]),
                .i_left       (w_link[g]),
                .o_level      (w_level[g]),
                .o_next_level (w_next[g]),
                .o_link       (w_link[g+1])
            );
        end
    endgenerate

    always_comb begin
        n_min = (i_level < r_min) ? i_level : r_min;
        n_max = (i_level > r_max) ? i_level : r_max;
    end

    assign w_first      = (r_count == '0) ? i_level : r_first;
    assign w_min_scaled = PROD_BITS'(n_min) * PROD_BITS'(MIN_SCALE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_min   <= '1;
            r_max   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_accept && w_last;
            if (w_accept) begin
                if (w_last) begin
                    r_count <= '0;
                    r_min   <= '1;
                    r_max   <= '0;
                end else begin
                    r_count <= r_count + CNT_BITS'(1);
                    r_min   <= n_min;
                    r_max   <= n_max;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && r_count == '0) begin
            r_first <= i_level;
        end
        if (w_accept && w_last) begin
            r_min_level    <= n_min;
            r_max_level    <= n_max;
            r_never_below  <= (w_min_scaled >= PROD_BITS'(n_max));
            r_consumption  <= {1'b0, w_first} - {1'b0, i_level};
            // odd count: both taps point at the middle cell
            r_median_twice <= {1'b0, w_next[MID_LO]} + {1'b0, w_next[MID_HI]};
        end
    end

    assign o_valid        = r_valid;
    assign o_min_level    = r_min_level;
    assign o_max_level    = r_max_level;
    assign o_never_below  = r_never_below;
    assign o_consumption  = r_consumption;
    assign o_median_twice = r_median_twice;

endmodule
